/* rtl/core/closest_point_of_approach_core_defines.svh */
// ----------------------------------------------------------------------------
// Closest point of approach core: assertion macros
// Shared property shorthands, clocked on i_clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef CLOSEST_POINT_OF_APPROACH_CORE_DEFINES_SVH
`define CLOSEST_POINT_OF_APPROACH_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/cpa_pkg.sv */
// ----------------------------------------------------------------------------
// CPA package
// Types and fixed constants shared by the closest point of approach core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpa_pkg;

    // Pipeline shape.
    localparam int TRIG_LAT    = 6;
    localparam int TW          = 24;
    localparam int VW          = 19;
    localparam int CLOSE_W     = 35;
    localparam int DIST_W      = 23;
    localparam int OUT_TDATA_W = 64;
    localparam int SQW         = 64;
    localparam int SQ_STEPS    = 32;
    localparam int CFG_IDX_W   = 3;

    // Configuration register indexes.
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_CONTACT_NORTH  = 3'd0;
    localparam t_cfg_idx CFG_CONTACT_EAST   = 3'd1;
    localparam t_cfg_idx CFG_CONTACT_COURSE = 3'd2;
    localparam t_cfg_idx CFG_CONTACT_SPEED  = 3'd3;
    localparam t_cfg_idx CFG_OWN_NORTH      = 3'd4;
    localparam t_cfg_idx CFG_OWN_EAST       = 3'd5;

    // Quarter-wave sine polynomial, Q30 magnitudes.
    typedef logic [30:0] t_coef;
    localparam t_coef PC1 = 31'd1686629713;
    localparam t_coef PC3 = 31'd693598668;
    localparam t_coef PC5 = 31'd85569306;
    localparam t_coef PC7 = 31'd5026995;
    localparam t_coef PC9 = 31'd172272;
    localparam t_coef PC_HORNER [4] = '{PC7, PC5, PC3, PC1};

    // Saturation limits.
    localparam logic [DIST_W-1:0] DIST_MAX  = 23'h7FFFFF;
    localparam logic [30:0]       Q4_LIM    = 31'h7FFFFFFF;
    localparam logic signed [63:0] CLOSE_MAX = 64'sd17179869183;
    localparam logic signed [63:0] CLOSE_MIN = -64'sd17179869184;

    // Control carried along the divider row.
    typedef struct packed {
        logic valid;
        logic use_t;
        logic ovf;
    } t_div_ctl;

    // Control carried along the square root row.
    typedef struct packed {
        logic valid;
        logic shr;
    } t_sqrt_ctl;

endpackage

/* rtl/core/cpa_sine.sv */
// ----------------------------------------------------------------------------
// CPA sine lane
// Pipelined Q15 sine of a 16-bit binary angle from a quarter-wave polynomial.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpa_sine (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [15:0]        i_angle,
    output logic signed [16:0] o_sine
);
    import cpa_pkg::*;

    logic [14:0] r_rr  [5];
    logic [1:0]  r_q   [5];
    logic [14:0] r_z2  [4];
    t_coef       r_acc [5];

    logic [14:0] n_rr0;
    logic [29:0] sq0;
    logic [45:0] prod [4];
    t_coef       n_acc [4];
    logic [45:0] fin;
    logic [31:0] fin_sh;
    logic [16:0] mag;

    // Fold the angle into the first quarter and square it.
    always_comb begin
        n_rr0 = i_angle[14] ? (15'd16384 - {1'b0, i_angle[13:0]}) : {1'b0, i_angle[13:0]};
        sq0   = n_rr0 * n_rr0;
    end

    // Horner steps, one multiply per stage.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            prod[k]  = r_acc[k] * r_z2[k];
            n_acc[k] = PC_HORNER[k] - prod[k][44:14];
        end
        fin    = r_acc[4] * r_rr[4];
        fin_sh = fin[45:14];
        mag    = 17'((33'(fin_sh) + 33'd16384) >> 15);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rr[0]  <= n_rr0;
            r_q[0]   <= i_angle[15:14];
            r_z2[0]  <= sq0[28:14];
            r_acc[0] <= PC9;
            for (int k = 1; k < 5; k++) begin
                r_rr[k]  <= r_rr[k-1];
                r_q[k]   <= r_q[k-1];
                r_acc[k] <= n_acc[k-1];
            end
            for (int k = 1; k < 4; k++) begin
                r_z2[k] <= r_z2[k-1];
            end
            o_sine <= r_q[4][1] ? -$signed(mag) : $signed(mag);
        end
    end

endmodule

/* rtl/core/cpa_div_cell.sv */
// ----------------------------------------------------------------------------
// CPA divider cell
// One restoring division step: settles one quotient bit and hands on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpa_div_cell #(
    parameter int DW  = 62,
    parameter int K2W = 36,
    parameter int SW  = 89,
    parameter int SH  = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  cpa_pkg::t_div_ctl        i_ctl,
    input  logic [DW-1:0]            i_rem,
    input  logic [K2W-1:0]           i_div,
    input  logic [cpa_pkg::TW-1:0]   i_quo,
    input  logic [SW-1:0]            i_side,
    output cpa_pkg::t_div_ctl        o_ctl,
    output logic [DW-1:0]            o_rem,
    output logic [K2W-1:0]           o_div,
    output logic [cpa_pkg::TW-1:0]   o_quo,
    output logic [SW-1:0]            o_side
);
    import cpa_pkg::*;

    logic [DW-1:0] trial;
    logic          fits;
    logic [DW-1:0] n_rem;
    logic [TW-1:0] n_quo;

    // Trial subtract of the shifted divisor.
    always_comb begin
        trial     = DW'(i_div) << SH;
        fits      = (i_rem >= trial);
        n_rem     = fits ? (i_rem - trial) : i_rem;
        n_quo     = i_quo;
        n_quo[SH] = fits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_div  <= i_div;
            o_quo  <= n_quo;
            o_side <= i_side;
        end
    end

endmodule

/* rtl/core/cpa_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// CPA square root cell
// One digit-by-digit integer square root step on a 64-bit radicand.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpa_sqrt_cell #(
    parameter int BP = 62
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  cpa_pkg::t_sqrt_ctl          i_ctl,
    input  logic [cpa_pkg::SQW-1:0]     i_rem,
    input  logic [cpa_pkg::SQW-1:0]     i_res,
    input  logic [cpa_pkg::CLOSE_W-1:0] i_close,
    output cpa_pkg::t_sqrt_ctl          o_ctl,
    output logic [cpa_pkg::SQW-1:0]     o_rem,
    output logic [cpa_pkg::SQW-1:0]     o_res,
    output logic [cpa_pkg::CLOSE_W-1:0] o_close
);
    import cpa_pkg::*;

    logic [SQW-1:0] bitv;
    logic [SQW-1:0] trial;
    logic           fits;

    // Compare against res + bit and update the partial root.
    always_comb begin
        bitv  = SQW'(1) << BP;
        trial = i_res + bitv;
        fits  = (i_rem >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem   <= fits ? (i_rem - trial) : i_rem;
            o_res   <= fits ? ((i_res >> 1) + bitv) : (i_res >> 1);
            o_close <= i_close;
        end
    end

endmodule

/* rtl/core/closest_point_of_approach_core.sv */
// ----------------------------------------------------------------------------
// Closest point of approach core
// Throughput: one trial per cycle; the whole row of cells advances together
// and holds only while a result beat waits on the output.
// Reset: synchronous active low; clears valids and configuration to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "closest_point_of_approach_core_defines.svh"

module closest_point_of_approach_core #(
    parameter int ANGLE_BITS    = 16,
    parameter int POSITION_BITS = 21
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Input beat, tdata from bit 0: own_course, own_speed, time_on_leg, zero pad.
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [((ANGLE_BITS+32+7)/8)*8-1:0]    i_s_axis_tdata,
    // Result beat, tdata from bit 0: cpa_distance, closure_rate, zero pad.
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [cpa_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,
    // Configuration writes.
    input  logic                                  i_cfg_we,
    input  logic [cpa_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [((POSITION_BITS > ANGLE_BITS) ?
                   ((POSITION_BITS > 16) ? POSITION_BITS : 16) :
                   ((ANGLE_BITS > 16) ? ANGLE_BITS : 16))-1:0] i_cfg_data
);
    import cpa_pkg::*;

    localparam int AW   = ANGLE_BITS;
    localparam int PB   = POSITION_BITS;
    localparam int DNW  = PB + 1;
    localparam int DVW  = DNW + VW;
    localparam int K1W  = DVW + 2;
    localparam int NKW  = K1W + 1;
    localparam int K2W  = 36;
    localparam int NW   = NKW + 15;
    localparam int DW   = (NW > K2W + TW + 1) ? NW : K2W + TW + 1;
    localparam int SW   = CLOSE_W + 16 + 2 * VW;
    localparam int TVW  = VW + TW + 1;
    localparam int PSW  = ((DNW + 16 > TVW) ? DNW + 16 : TVW) + 1;
    localparam int K0W  = 2 * DNW + 1;

    // ------------------------------------------------------------------
    // Configuration registers.
    logic [PB-1:0] r_cn, r_ce, r_on, r_oe;
    logic [AW-1:0] r_cc;
    logic [15:0]   r_cs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cn <= '0;
            r_ce <= '0;
            r_cc <= '0;
            r_cs <= '0;
            r_on <= '0;
            r_oe <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CONTACT_NORTH:  r_cn <= i_cfg_data[PB-1:0];
                CFG_CONTACT_EAST:   r_ce <= i_cfg_data[PB-1:0];
                CFG_CONTACT_COURSE: r_cc <= i_cfg_data[AW-1:0];
                CFG_CONTACT_SPEED:  r_cs <= i_cfg_data[15:0];
                CFG_OWN_NORTH:      r_on <= i_cfg_data[PB-1:0];
                CFG_OWN_EAST:       r_oe <= i_cfg_data[PB-1:0];
                default: ;
            endcase
        end
    end

    // Relative position and its squared length follow the configuration.
    logic signed [DNW-1:0]   r_dn, r_de;
    logic [K0W-1:0]          r_k0;
    logic signed [2*DNW-1:0] dn2, de2;

    always_comb begin
        dn2 = r_dn * r_dn;
        de2 = r_de * r_de;
    end

    always_ff @(posedge i_clk) begin
        r_dn <= $signed({r_on[PB-1], r_on}) - $signed({r_cn[PB-1], r_cn});
        r_de <= $signed({r_oe[PB-1], r_oe}) - $signed({r_ce[PB-1], r_ce});
        r_k0 <= {1'b0, $unsigned(dn2)} + {1'b0, $unsigned(de2)};
    end

    // ------------------------------------------------------------------
    // Flow control: every stage moves while the output register can take.
    logic r_out_valid;
    logic en;
    logic accept;

    assign en              = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign accept          = i_s_axis_tvalid && en;

    logic [AW-1:0] in_oc;
    logic [15:0]   in_os, in_tol;
    logic [15:0]   own_a16, con_a16;

    assign in_oc  = i_s_axis_tdata[AW-1:0];
    assign in_os  = i_s_axis_tdata[AW+15:AW];
    assign in_tol = i_s_axis_tdata[AW+31:AW+16];

    // Bring binary angles to 16 bits.
    if (AW >= 16) begin : g_ang_down
        assign own_a16 = in_oc[AW-1 -: 16];
        assign con_a16 = r_cc[AW-1 -: 16];
    end else begin : g_ang_up
        assign own_a16 = {in_oc, {(16-AW){1'b0}}};
        assign con_a16 = {r_cc, {(16-AW){1'b0}}};
    end

    // ------------------------------------------------------------------
    // Trig lanes and the side data that runs beside them.
    logic signed [16:0] own_cos, own_sin, con_cos, con_sin;

    cpa_sine u_own_cos (.i_clk, .i_en(en), .i_angle(own_a16 + 16'd16384), .o_sine(own_cos));
    cpa_sine u_own_sin (.i_clk, .i_en(en), .i_angle(own_a16),             .o_sine(own_sin));
    cpa_sine u_con_cos (.i_clk, .i_en(en), .i_angle(con_a16 + 16'd16384), .o_sine(con_cos));
    cpa_sine u_con_sin (.i_clk, .i_en(en), .i_angle(con_a16),             .o_sine(con_sin));

    logic        r_tv     [TRIG_LAT];
    logic        r_tmatch [TRIG_LAT];
    logic [15:0] r_tos    [TRIG_LAT];
    logic [15:0] r_ttol   [TRIG_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TRIG_LAT; k++) r_tv[k] <= 1'b0;
        end else if (en) begin
            r_tv[0] <= i_s_axis_tvalid;
            for (int k = 1; k < TRIG_LAT; k++) r_tv[k] <= r_tv[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tmatch[0] <= (in_oc == r_cc) && (in_os == r_cs);
            r_tos[0]    <= in_os;
            r_ttol[0]   <= in_tol;
            for (int k = 1; k < TRIG_LAT; k++) begin
                r_tmatch[k] <= r_tmatch[k-1];
                r_tos[k]    <= r_tos[k-1];
                r_ttol[k]   <= r_ttol[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Velocity products, velocities, dot products, then k2, -k1, closure.
    logic                  r1_v, r2_v, r3_v, r4_v;
    logic                  r1_match, r2_match, r3_match;
    logic [15:0]           r1_tol, r2_tol, r3_tol, r4_tol;
    logic signed [33:0]    r1_pon, r1_pcn, r1_poe, r1_pce;
    logic signed [VW-1:0]  r2_vn, r2_ve, r3_vn, r3_ve, r4_vn, r4_ve;
    logic signed [DVW-1:0] r3_dnvn, r3_deve;
    logic [K2W-1:0]        r3_vn2, r3_ve2, r4_k2;
    logic                  r4_use;
    logic [DW-1:0]         r4_n;
    logic [CLOSE_W-1:0]    r4_close;

    logic signed [34:0]      diff_n, diff_e;
    logic signed [2*VW-1:0]  vn2_full, ve2_full;
    logic signed [DVW:0]     sumk;
    logic signed [K1W-1:0]   k1;
    logic signed [NKW-1:0]   negk1, negk1_sh;
    logic signed [63:0]      close64;
    logic [CLOSE_W-1:0]      close_sat;
    logic [K2W-1:0]          k2_sum;
    logic                    use_n;

    always_comb begin
        diff_n   = {r1_pon[33], r1_pon} - {r1_pcn[33], r1_pcn} + 35'sd16384;
        diff_e   = {r1_poe[33], r1_poe} - {r1_pce[33], r1_pce} + 35'sd16384;
        vn2_full = r2_vn * r2_vn;
        ve2_full = r2_ve * r2_ve;
        sumk     = {r3_dnvn[DVW-1], r3_dnvn} + {r3_deve[DVW-1], r3_deve};
        k1       = {sumk, 1'b0};
        negk1    = -{k1[K1W-1], k1};
        negk1_sh = negk1 >>> 8;
        close64  = 64'(negk1_sh);
        if (close64 > CLOSE_MAX)       close_sat = CLOSE_MAX[CLOSE_W-1:0];
        else if (close64 < CLOSE_MIN)  close_sat = CLOSE_MIN[CLOSE_W-1:0];
        else                           close_sat = close64[CLOSE_W-1:0];
        k2_sum   = r3_vn2 + r3_ve2;
        use_n    = !r3_match && (k2_sum != '0) && (negk1 > 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (en) begin
            r1_v <= r_tv[TRIG_LAT-1];
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_match <= r_tmatch[TRIG_LAT-1];
            r1_tol   <= r_ttol[TRIG_LAT-1];
            r1_pon   <= $signed({1'b0, r_tos[TRIG_LAT-1]}) * own_cos;
            r1_pcn   <= $signed({1'b0, r_cs}) * con_cos;
            r1_poe   <= $signed({1'b0, r_tos[TRIG_LAT-1]}) * own_sin;
            r1_pce   <= $signed({1'b0, r_cs}) * con_sin;

            r2_match <= r1_match;
            r2_tol   <= r1_tol;
            r2_vn    <= diff_n[33:15];
            r2_ve    <= diff_e[33:15];

            r3_match <= r2_match;
            r3_tol   <= r2_tol;
            r3_vn    <= r2_vn;
            r3_ve    <= r2_ve;
            r3_dnvn  <= r_dn * r2_vn;
            r3_deve  <= r_de * r2_ve;
            r3_vn2   <= vn2_full[K2W-1:0];
            r3_ve2   <= ve2_full[K2W-1:0];

            r4_tol   <= r3_tol;
            r4_vn    <= r3_vn;
            r4_ve    <= r3_ve;
            r4_k2    <= k2_sum;
            r4_use   <= use_n;
            r4_n     <= use_n ? (DW'($unsigned(negk1)) << 15) : '0;
            r4_close <= r3_match ? '0 : close_sat;
        end
    end

    // ------------------------------------------------------------------
    // Quotient range check, then the divider row.
    t_div_ctl       r5_ctl;
    logic [DW-1:0]  r5_n;
    logic [K2W-1:0] r5_k2;
    logic [SW-1:0]  r5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_ctl <= '0;
        end else if (en) begin
            r5_ctl.valid <= r4_v;
            r5_ctl.use_t <= r4_use;
            r5_ctl.ovf   <= (r4_n >= (DW'(r4_k2) << TW));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_n    <= r4_n;
            r5_k2   <= r4_k2;
            r5_side <= {r4_close, r4_tol, r4_ve, r4_vn};
        end
    end

    t_div_ctl       div_ctl  [TW+1];
    logic [DW-1:0]  div_rem  [TW+1];
    logic [K2W-1:0] div_div  [TW+1];
    logic [TW-1:0]  div_quo  [TW+1];
    logic [SW-1:0]  div_side [TW+1];

    assign div_ctl[0]  = r5_ctl;
    assign div_rem[0]  = r5_n;
    assign div_div[0]  = r5_k2;
    assign div_quo[0]  = '0;
    assign div_side[0] = r5_side;

    for (genvar g = 0; g < TW; g++) begin : g_div
        cpa_div_cell #(.DW(DW), .K2W(K2W), .SW(SW), .SH(TW - 1 - g)) u_cell (
            .i_clk,
            .i_rst_n,
            .i_en   (en),
            .i_ctl  (div_ctl[g]),
            .i_rem  (div_rem[g]),
            .i_div  (div_div[g]),
            .i_quo  (div_quo[g]),
            .i_side (div_side[g]),
            .o_ctl  (div_ctl[g+1]),
            .o_rem  (div_rem[g+1]),
            .o_div  (div_div[g+1]),
            .o_quo  (div_quo[g+1]),
            .o_side (div_side[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Clamp the time, move the relative position, square the components.
    logic signed [VW-1:0]  dv_vn, dv_ve;
    logic [15:0]           dv_tol;
    logic [CLOSE_W-1:0]    dv_close;
    logic [TW-1:0]         tmax, dv_q;

    assign {dv_close, dv_tol, dv_ve, dv_vn} = div_side[TW];
    assign dv_q = div_quo[TW];
    assign tmax = {dv_tol, 8'b0};

    logic                  r6_v, r7_v, r8_v, r9_v;
    logic                  r6_use, r7_use, r8_use, r9_use;
    logic [TW-1:0]         r6_t;
    logic signed [VW-1:0]  r6_vn, r6_ve;
    logic [CLOSE_W-1:0]    r6_close, r7_close, r8_close, r9_close;
    logic signed [TVW-1:0] r7_vnt, r7_vet;
    logic [30:0]           r8_pn, r8_pe;
    logic [61:0]           r9_pn2, r9_pe2;

    logic signed [PSW-1:0] ps_n, ps_e, sh_n, sh_e, mag_n, mag_e;
    logic [30:0]           sat_n, sat_e;

    always_comb begin
        ps_n  = (PSW'(r_dn) <<< 16) + PSW'(r7_vnt);
        ps_e  = (PSW'(r_de) <<< 16) + PSW'(r7_vet);
        sh_n  = ps_n >>> 12;
        sh_e  = ps_e >>> 12;
        mag_n = sh_n[PSW-1] ? -sh_n : sh_n;
        mag_e = sh_e[PSW-1] ? -sh_e : sh_e;
        sat_n = ($unsigned(mag_n) > PSW'(Q4_LIM)) ? Q4_LIM : mag_n[30:0];
        sat_e = ($unsigned(mag_e) > PSW'(Q4_LIM)) ? Q4_LIM : mag_e[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r9_v <= 1'b0;
        end else if (en) begin
            r6_v <= div_ctl[TW].valid;
            r7_v <= r6_v;
            r8_v <= r7_v;
            r9_v <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_t     <= (div_ctl[TW].ovf || dv_q >= tmax) ? tmax : dv_q;
            r6_use   <= div_ctl[TW].use_t && (div_ctl[TW].ovf || dv_q != '0);
            r6_vn    <= dv_vn;
            r6_ve    <= dv_ve;
            r6_close <= dv_close;

            r7_vnt   <= r6_vn * $signed({1'b0, r6_t});
            r7_vet   <= r6_ve * $signed({1'b0, r6_t});
            r7_use   <= r6_use;
            r7_close <= r6_close;

            r8_pn    <= sat_n;
            r8_pe    <= sat_e;
            r8_use   <= r7_use;
            r8_close <= r7_close;

            r9_pn2   <= r8_pn * r8_pn;
            r9_pe2   <= r8_pe * r8_pe;
            r9_use   <= r8_use;
            r9_close <= r8_close;
        end
    end

    // ------------------------------------------------------------------
    // Radicand select, then the square root row.
    t_sqrt_ctl          r10_ctl;
    logic [SQW-1:0]     r10_x;
    logic [CLOSE_W-1:0] r10_close;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_ctl <= '0;
        end else if (en) begin
            r10_ctl.valid <= r9_v;
            r10_ctl.shr   <= r9_use;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_x     <= r9_use ? (SQW'(r9_pn2) + SQW'(r9_pe2)) : SQW'(r_k0);
            r10_close <= r9_close;
        end
    end

    t_sqrt_ctl          sq_ctl   [SQ_STEPS+1];
    logic [SQW-1:0]     sq_rem   [SQ_STEPS+1];
    logic [SQW-1:0]     sq_res   [SQ_STEPS+1];
    logic [CLOSE_W-1:0] sq_close [SQ_STEPS+1];

    assign sq_ctl[0]   = r10_ctl;
    assign sq_rem[0]   = r10_x;
    assign sq_res[0]   = '0;
    assign sq_close[0] = r10_close;

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
        cpa_sqrt_cell #(.BP(SQW - 2 - 2 * j)) u_cell (
            .i_clk,
            .i_rst_n,
            .i_en    (en),
            .i_ctl   (sq_ctl[j]),
            .i_rem   (sq_rem[j]),
            .i_res   (sq_res[j]),
            .i_close (sq_close[j]),
            .o_ctl   (sq_ctl[j+1]),
            .o_rem   (sq_rem[j+1]),
            .o_res   (sq_res[j+1]),
            .o_close (sq_close[j+1])
        );
    end

    // ------------------------------------------------------------------
    // Output register.
    logic [SQW-1:0]     dist_full;
    logic [DIST_W-1:0]  dist_sat;
    logic [DIST_W-1:0]  r_out_dist;
    logic [CLOSE_W-1:0] r_out_close;

    always_comb begin
        dist_full = sq_ctl[SQ_STEPS].shr ? (sq_res[SQ_STEPS] >> 4) : sq_res[SQ_STEPS];
        dist_sat  = (dist_full > SQW'(DIST_MAX)) ? DIST_MAX : dist_full[DIST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= sq_ctl[SQ_STEPS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_dist  <= dist_sat;
            r_out_close <= sq_close[SQ_STEPS];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-CLOSE_W-DIST_W){1'b0}}, r_out_close, r_out_dist};

    // ------------------------------------------------------------------
    // Checks.
    `CPA_ASSERT_NEXT(a_accept_enters, accept, r_tv[0], "accepted beat did not enter the pipe")
    `CPA_ASSERT_NOW(a_sqrt_remainder, sq_ctl[SQ_STEPS].valid,
        sq_rem[SQ_STEPS] <= (sq_res[SQ_STEPS] << 1), "square root remainder too large")
    `CPA_ASSERT_NEXT(a_stall_holds, !en, $stable(sq_ctl[SQ_STEPS]), "stalled pipe moved")

endmodule

/* test/tb_closest_point_of_approach_core.sv */
// ----------------------------------------------------------------------------
// Closest point of approach core testbench
// Drives trial course, speed and leg time beats under several contact and
// ownship settings, and checks every result beat field by field against a
// predictor that tracks the configuration written so far. A directed table
// comes first, then random trials in bursts while the output stalls at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_closest_point_of_approach_core;

    import cpa_pkg::*;

    localparam t_cfg_idx CFG_SPARE_A = 3'd6;
    localparam t_cfg_idx CFG_SPARE_B = 3'd7;
    localparam int RANDOM_ITEMS = 1600;
    localparam int PHASE_ITEMS  = 200;

    typedef struct packed {
        logic [22:0] distance;
        logic [34:0] close;
    } cpa_result_t;

    typedef struct packed {
        bit        is_cfg;
        t_cfg_idx  idx;
        bit [20:0] val;
        bit [15:0] crs;
        bit [15:0] spd;
        bit [15:0] tol;
        bit        known;
        bit [22:0] distance;
        bit [34:0] close;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_we = 1'b0;
    t_cfg_idx    cfg_index = '0;
    logic [20:0] cfg_data = '0;

    // Shadow of the configuration registers.
    bit [20:0] contact_n, contact_e, own_n, own_e;
    bit [15:0] contact_crs, contact_spd;

    cpa_result_t pending_cpa[$];
    int          error_count = 0;
    int          stall_mode = 0;

    closest_point_of_approach_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Sine of r/16384 of a quarter circle, Q15, degree 9 odd polynomial in Q30.
    function automatic longint quarter_sine(bit [63:0] r);
        bit [63:0] z2, acc;
        z2  = (r * r) >> 14;
        acc = 64'(PC9);
        acc = 64'(PC7) - ((acc * z2) >> 14);
        acc = 64'(PC5) - ((acc * z2) >> 14);
        acc = 64'(PC3) - ((acc * z2) >> 14);
        acc = 64'(PC1) - ((acc * z2) >> 14);
        acc = (acc * r) >> 14;
        return longint'((acc + 64'd16384) >> 15);
    endfunction

    function automatic longint angle_sine(bit [15:0] a);
        longint s;
        if (a[14]) begin
            s = quarter_sine(64'd16384 - 64'(a[13:0]));
        end else begin
            s = quarter_sine(64'(a[13:0]));
        end
        return a[15] ? -s : s;
    endfunction

    function automatic bit [63:0] floor_sqrt(bit [63:0] x);
        bit [63:0] res, b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic bit [63:0] mag_squared(longint x);
        bit [63:0] m;
        m = (x < 0) ? 64'(-x) : 64'(x);
        return m * m;
    endfunction

    function automatic bit [22:0] clip_distance(bit [63:0] d);
        return (d > 64'(DIST_MAX)) ? DIST_MAX : d[22:0];
    endfunction

    function automatic longint clip_q4(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483647) return -64'sd2147483647;
        return x;
    endfunction

    // Expected distance and closure rate for one trial leg.
    function automatic cpa_result_t cpa_predict(bit [15:0] crs, bit [15:0] spd,
                                                bit [15:0] tol);
        cpa_result_t res;
        longint dn, de, co, so, cc, sc, vn, ve, k1, negk1, close, pn, pe;
        bit [63:0] k0, k2, t, tmax;
        dn = longint'($signed(own_n)) - longint'($signed(contact_n));
        de = longint'($signed(own_e)) - longint'($signed(contact_e));
        k0 = mag_squared(dn) + mag_squared(de);
        res.distance = clip_distance(floor_sqrt(k0));
        res.close = '0;
        if (crs == contact_crs && spd == contact_spd) return res;
        co = angle_sine(crs + 16'd16384);
        so = angle_sine(crs);
        cc = angle_sine(contact_crs + 16'd16384);
        sc = angle_sine(contact_crs);
        vn = (longint'(spd) * co - longint'(contact_spd) * cc + 16384) >>> 15;
        ve = (longint'(spd) * so - longint'(contact_spd) * sc + 16384) >>> 15;
        k2 = mag_squared(vn) + mag_squared(ve);
        k1 = 2 * (dn * vn + de * ve);
        negk1 = -k1;
        if (k2 != 0 && negk1 > 0) begin
            t    = (64'(negk1) * 64'd32768) / k2;
            tmax = 64'(tol) << 8;
            if (t > 0) begin
                if (t >= tmax) t = tmax;
                pn = clip_q4((dn * 65536 + vn * longint'(t)) >>> 12);
                pe = clip_q4((de * 65536 + ve * longint'(t)) >>> 12);
                res.distance = clip_distance(floor_sqrt(mag_squared(pn) + mag_squared(pe)) >> 4);
            end
        end
        close = negk1 >>> 8;
        if (close > CLOSE_MAX) close = CLOSE_MAX;
        if (close < CLOSE_MIN) close = CLOSE_MIN;
        res.close = close[34:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Present one trial beat and hold it until it is taken.
    task automatic send_trial(bit [15:0] crs, bit [15:0] spd, bit [15:0] tol,
                              bit known, cpa_result_t typed);
        s_tvalid <= 1'b1;
        s_tdata  <= {tol, spd, crs};
        do @(posedge i_clk); while (!s_tready);
        pending_cpa.insert(pending_cpa.size(), known ? typed : cpa_predict(crs, spd, tol));
    endtask

    task automatic drain_results();
        while (pending_cpa.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write, only issued with the pipeline empty.
    task automatic write_register(t_cfg_idx idx, bit [20:0] val);
        s_tvalid <= 1'b0;
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CONTACT_NORTH:  contact_n = val;
            CFG_CONTACT_EAST:   contact_e = val;
            CFG_CONTACT_COURSE: contact_crs = val[15:0];
            CFG_CONTACT_SPEED:  contact_spd = val[15:0];
            CFG_OWN_NORTH:      own_n = val;
            CFG_OWN_EAST:       own_e = val;
            default: ;
        endcase
    endtask

    // Result beat checker.
    always @(posedge i_clk) begin
        cpa_result_t want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_cpa.size() == 0) begin
                report_mismatch("unexpected beat", longint'(m_tdata[22:0]), 0);
            end else begin
                want = pending_cpa.pop_front();
                if (m_tdata[22:0] !== want.distance)
                    report_mismatch("cpa_distance", longint'(m_tdata[22:0]),
                                    longint'(want.distance));
                if (m_tdata[57:23] !== want.close)
                    report_mismatch("closure_rate", longint'($signed(m_tdata[57:23])),
                                    longint'($signed(want.close)));
                if (m_tdata[63:58] !== 6'd0)
                    report_mismatch("tdata pad", longint'(m_tdata[63:58]), 0);
            end
        end
    end

    // Output stall pattern, changing character at random.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    initial begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    dir_row_t dir_rows [22] = '{
        // Reset state: zero offset always gives zero distance and closure.
        '{0, 3'd0, 21'd0, 16'd0, 16'd0, 16'd0, 1, 23'd0, 35'd0},
        '{0, 3'd0, 21'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 23'd0, 35'd0},
        '{0, 3'd0, 21'd0, 16'd16384, 16'd256, 16'd10, 1, 23'd0, 35'd0},
        // Widest north offset.
        '{1, CFG_CONTACT_NORTH, 21'h100000, 16'd0, 16'd0, 16'd0, 0, 23'd0, 35'd0},
        '{1, CFG_OWN_NORTH, 21'h0FFFFF, 16'd0, 16'd0, 16'd0, 0, 23'd0, 35'd0},
        '{0, 3'd0, 21'd0, 16'd0, 16'd0, 16'd0, 1, 23'd2097151, 35'd0},
        '{0, 3'd0, 21'd0, 16'd0, 16'd256, 16'd100, 0, 23'd0, 35'd0},
        '{0, 3'd0, 21'd0, 16'd32768, 16'hFFFF, 16'hFFFF, 0, 23'd0, 35'd0},
        '{0, 3'd0, 21'd0, 16'd32768, 16'hFFFF, 16'd0, 0, 23'd0, 35'd0},
        // Contact at full speed heading south; a matching trial.
        '{1, CFG_CONTACT_SPEED, 21'h1FFFFF, 16'd0, 16'd0, 16'd0, 0, 23'd0, 35'd0},
        '{1, CFG_CONTACT_COURSE, 21'd32768, 16'd0, 16'd0, 16'd0, 0, 23'd0, 35'd0},
        '{0, 3'd0, 21'd0, 16'd32768, 16'hFFFF, 16'd5, 1, 23'd2097151, 35'd0},
        '{0, 3'd0, 21'd0, 16'd0, 16'hFFFF, 16'hFFFF, 0, 23'd0, 35'd0},
        // Writes to unused indexes leave everything alone.
        '{1, CFG_SPARE_A, 21'h1FFFFF, 16'd0, 16'd0, 16'd0, 0, 23'd0, 35'd0},
        '{1, CFG_SPARE_B, 21'd0, 16'd0, 16'd0, 16'd0, 0, 23'd0, 35'd0},
        '{0, 3'd0, 21'd0, 16'd32768, 16'hFFFF, 16'd7, 1, 23'd2097151, 35'd0},
        '{1, CFG_CONTACT_EAST, 21'h0FFFFF, 16'd0, 16'd0, 16'd0, 0, 23'd0, 35'd0},
        '{1, CFG_OWN_EAST, 21'h100000, 16'd0, 16'd0, 16'd0, 0, 23'd0, 35'd0},
        '{0, 3'd0, 21'd0, 16'd49152, 16'd1000, 16'd1000, 0, 23'd0, 35'd0},
        '{0, 3'd0, 21'd0, 16'd16384, 16'hFFFF, 16'hFFFF, 0, 23'd0, 35'd0},
        '{1, CFG_OWN_NORTH, 21'd0, 16'd0, 16'd0, 16'd0, 0, 23'd0, 35'd0},
        '{0, 3'd0, 21'd0, 16'd0, 16'd0, 16'd300, 0, 23'd0, 35'd0}
    };

    initial begin
        int sent, burst, kind, scale;
        bit [15:0] crs, spd, tol;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                write_register(dir_rows[i].idx, dir_rows[i].val);
            end else begin
                send_trial(dir_rows[i].crs, dir_rows[i].spd, dir_rows[i].tol,
                           dir_rows[i].known,
                           '{dir_rows[i].distance, dir_rows[i].close});
                if ($urandom_range(0, 1)) begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end
            end
        end

        // Random phases, each under a fresh setting.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            kind = (sent / PHASE_ITEMS) % 4;
            scale = (kind == 1) ? 5000 : 100000;
            for (int r = 0; r < 6; r++) begin
                bit [20:0] v;
                if (kind == 0) begin
                    v = 21'($urandom());
                end else if (kind == 3) begin
                    v = $urandom_range(0, 1) ? 21'h0FFFFF : 21'h100000;
                    if (r == CFG_CONTACT_COURSE || r == CFG_CONTACT_SPEED)
                        v = $urandom_range(0, 1) ? 21'h1FFFFF : 21'h0;
                end else if (r == CFG_CONTACT_COURSE) begin
                    v = 21'($urandom());
                end else if (r == CFG_CONTACT_SPEED) begin
                    v = 21'($urandom_range(0, 4000));
                end else begin
                    v = 21'($signed($urandom_range(0, 2 * scale)) - scale);
                end
                write_register(t_cfg_idx'(r), v);
            end
            if ($urandom_range(0, 1))
                write_register(t_cfg_idx'(CFG_SPARE_A + $urandom_range(0, 1)),
                               21'($urandom()));
            for (int n = 0; n < PHASE_ITEMS && sent < RANDOM_ITEMS; ) begin
                burst = $urandom_range(1, 30);
                for (int b = 0; b < burst && n < PHASE_ITEMS; b++) begin
                    crs = 16'($urandom());
                    spd = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                       : 16'($urandom_range(0, 4000));
                    tol = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                       : 16'($urandom_range(0, 600));
                    case ($urandom_range(0, 19))
                        0:  begin crs = contact_crs; spd = contact_spd; end
                        1:  crs = contact_crs;
                        2:  spd = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
                        3:  tol = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
                        default: ;
                    endcase
                    send_trial(crs, spd, tol, 1'b0, '0);
                    n++;
                    sent++;
                end
                if ($urandom_range(0, 9) < 7) begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end
            end
        end
        s_tvalid <= 1'b0;

        // Let every outstanding result arrive, then a short quiet tail.
        while (pending_cpa.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/cpa_pkg.sv
rtl/core/cpa_sine.sv
rtl/core/cpa_div_cell.sv
rtl/core/cpa_sqrt_cell.sv
rtl/core/closest_point_of_approach_core.sv
test/tb_closest_point_of_approach_core.sv
